### rtl/core/prce_pkg.sv
// Shared constants, widths and control types for the palette row color expander.
`default_nettype none
package prce_pkg;

   // Palette geometry
   localparam int PALETTE_ROWS = 64;
   localparam int MAX_SHADES   = 8;
   localparam int ROW_W        = $clog2(PALETTE_ROWS);
   localparam int SHADE_W      = $clog2(MAX_SHADES);
   localparam int PAL_DEPTH    = PALETTE_ROWS * MAX_SHADES;
   localparam int PAL_AW       = ROW_W + SHADE_W;
   localparam int LEN_W        = $clog2(MAX_SHADES + 1);
   localparam int ROWCNT_W     = $clog2(PALETTE_ROWS + 1);

   // Field widths
   localparam int COLOR_W      = 32;
   localparam int COORD_W      = 12;
   localparam int DEST_X_W     = 15;
   localparam int NUM_W        = 3;
   localparam int CNT_W        = 3;
   localparam int ROW_COUNT_W  = 7;
   localparam int CSR_DATA_W   = 12;
   localparam int CSR_IDX_W    = 2;

   // Stream widths
   localparam int REQ_DATA_W   = 104;
   localparam int RSP_DATA_W   = 64;
   localparam int RSP_USER_W   = 2;

   // Request kinds carried on req_tuser
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_PIXEL = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_EXPANSION_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_WIDTH    = 2'd2;

   // Register reset values
   localparam logic [COORD_W-1:0] REGION_WIDTH_RESET = 12'd1;

   // Controller to datapath commands
   typedef struct packed {
      logic load_entry;   // write the palette entry of the accepted load
      logic start_pixel;  // capture the accepted pixel
      logic srch_rd;      // read leader and length of the current row
      logic srch_next;    // advance to the next row
      logic srch_hit;     // record the current row as the match
      logic emit_rd;      // read the color of the current copy
      logic emit_load;    // load the result register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic cnt_zero;     // expansion count is zero
      logic limit_zero;   // no rows are searched
      logic row_match;    // row just read matches the pixel
      logic row_last;     // row just read is the last to search
      logic shade_last;   // current copy is the final one
      logic out_stall;    // result register holds an untaken result
   } status_type;

endpackage
`default_nettype wire

### rtl/core/prce_ctrl.sv
// Sequencing state machine of the palette row color expander.
`default_nettype none
module prce_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   input  wire                  req_kind,
   output logic                 req_tready,
   input  prce_pkg::status_type sts,
   output prce_pkg::cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_SRCH_RD  = 5'b00010,
      ST_SRCH_CHK = 5'b00100,
      ST_EMIT_RD  = 5'b01000,
      ST_EMIT_CHK = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_kind == prce_pkg::REQ_LOAD) begin
                  cmd.load_entry = 1'b1;
               end else if (!sts.cnt_zero) begin
                  cmd.start_pixel = 1'b1;
                  state_in = sts.limit_zero ? ST_EMIT_RD : ST_SRCH_RD;
               end
            end
         end
         ST_SRCH_RD: begin
            cmd.srch_rd = 1'b1;
            state_in    = ST_SRCH_CHK;
         end
         ST_SRCH_CHK: begin
            if (sts.row_match) begin
               cmd.srch_hit = 1'b1;
               state_in     = ST_EMIT_RD;
            end else begin
               cmd.srch_next = 1'b1;
               state_in      = sts.row_last ? ST_EMIT_RD : ST_SRCH_RD;
            end
         end
         ST_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
            state_in    = ST_EMIT_CHK;
         end
         ST_EMIT_CHK: begin
            // wait here while the result register holds a result that is not being taken
            if (!sts.out_stall) begin
               cmd.emit_load = 1'b1;
               state_in      = sts.shade_last ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

### rtl/core/prce_datapath.sv
// Palette storage, row search compare, copy addressing and result register.
`default_nettype none
module prce_datapath (
   input  wire                                     clock,
   input  wire                                     reset,
   // configuration writes
   input  wire                                     csr_we,
   input  wire  [prce_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire  [prce_pkg::CSR_DATA_W-1:0]         csr_wdata,
   // request payload
   input  wire  [prce_pkg::REQ_DATA_W-1:0]         req_tdata,
   input  wire                                     req_tlast,
   // result handshake and payload
   input  wire                                     rsp_tready,
   output logic                                    rsp_tvalid,
   output logic [prce_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic [prce_pkg::RSP_USER_W-1:0]         rsp_tuser,
   output logic                                    rsp_tlast,
   // controller link
   input  prce_pkg::cmd_type                       cmd,
   output prce_pkg::status_type                    sts
);

   // request fields
   logic [prce_pkg::ROW_W-1:0]   in_row;
   logic [prce_pkg::SHADE_W-1:0] in_shade;
   logic [prce_pkg::COLOR_W-1:0] in_entry_color;
   logic [prce_pkg::COLOR_W-1:0] in_pixel_color;
   logic [prce_pkg::COORD_W-1:0] in_pixel_x;
   logic [prce_pkg::COORD_W-1:0] in_pixel_y;

   assign in_row         = req_tdata[5:0];
   assign in_shade       = req_tdata[8:6];
   assign in_entry_color = req_tdata[40:9];
   assign in_pixel_color = req_tdata[72:41];
   assign in_pixel_x     = req_tdata[84:73];
   assign in_pixel_y     = req_tdata[96:85];

   // configuration registers
   logic [prce_pkg::CNT_W-1:0]       exp_count_ff;
   logic [prce_pkg::ROW_COUNT_W-1:0] row_count_ff;
   logic [prce_pkg::COORD_W-1:0]     width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_count_ff <= '0;
         row_count_ff <= '0;
         width_ff     <= prce_pkg::REGION_WIDTH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            prce_pkg::CSR_EXPANSION_COUNT: exp_count_ff <= csr_wdata[prce_pkg::CNT_W-1:0];
            prce_pkg::CSR_ROW_COUNT:       row_count_ff <= csr_wdata[prce_pkg::ROW_COUNT_W-1:0];
            prce_pkg::CSR_REGION_WIDTH:    width_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // pixel context
   logic [prce_pkg::COLOR_W-1:0]  pcolor_ff;
   logic [prce_pkg::COORD_W-1:0]  py_ff;
   logic [prce_pkg::DEST_X_W-1:0] dx_ff;
   logic [prce_pkg::NUM_W-1:0]    n_ff;
   logic [prce_pkg::ROWCNT_W-1:0] row_ctr_ff;
   logic [prce_pkg::ROW_W-1:0]    hit_row_ff;
   logic [prce_pkg::LEN_W-1:0]    hit_len_ff;
   logic                          hit_ff;
   logic [prce_pkg::DEST_X_W-1:0] dx_in;

   assign dx_in = dx_ff + prce_pkg::DEST_X_W'(width_ff);

   always_ff @(posedge clock) begin
      if (cmd.start_pixel) begin
         pcolor_ff <= in_pixel_color;
         py_ff     <= in_pixel_y;
         dx_ff     <= prce_pkg::DEST_X_W'(in_pixel_x);
         n_ff      <= prce_pkg::NUM_W'(1);
      end else if (cmd.emit_load) begin
         dx_ff <= dx_in;
         n_ff  <= n_ff + 1'b1;
      end
   end

   // palette color memory: one write port, one registered read port
   logic [prce_pkg::COLOR_W-1:0] pal_mem [prce_pkg::PAL_DEPTH];
   logic [prce_pkg::COLOR_W-1:0] pal_rd_ff;
   logic [prce_pkg::PAL_AW-1:0]  pal_raddr;

   assign pal_raddr = cmd.emit_rd
                    ? {hit_row_ff, prce_pkg::SHADE_W'(n_ff)}
                    : {row_ctr_ff[prce_pkg::ROW_W-1:0], prce_pkg::SHADE_W'(0)};

   always_ff @(posedge clock) begin
      if (cmd.load_entry) begin
         pal_mem[{in_row, in_shade}] <= in_entry_color;
      end
      if (cmd.srch_rd || cmd.emit_rd) begin
         pal_rd_ff <= pal_mem[pal_raddr];
      end
   end

   // row length memory, with per-row valid bits standing in for the reset clear
   logic [prce_pkg::LEN_W-1:0]     len_mem [prce_pkg::PALETTE_ROWS];
   logic [prce_pkg::PALETTE_ROWS-1:0] len_vld_ff;
   logic [prce_pkg::LEN_W-1:0]     len_rd;
   logic [prce_pkg::LEN_W-1:0]     len_mem_rd_ff;
   logic [prce_pkg::ROW_W-1:0]     len_raddr;
   logic                           len_wr;

   assign len_wr    = cmd.load_entry && req_tlast;
   assign len_raddr = row_ctr_ff[prce_pkg::ROW_W-1:0];

   always_ff @(posedge clock) begin
      if (len_wr) begin
         len_mem[in_row] <= prce_pkg::LEN_W'(in_shade) + 1'b1;
      end
      if (cmd.srch_rd) begin
         len_mem_rd_ff <= len_mem[len_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_vld_ff <= '0;
      end else if (len_wr) begin
         len_vld_ff[in_row] <= 1'b1;
      end
   end

   logic len_vld_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.srch_rd) begin
         len_vld_rd_ff <= len_vld_ff[len_raddr];
      end
   end

   assign len_rd = len_vld_rd_ff ? len_mem_rd_ff : '0;

   // row search
   logic [prce_pkg::ROWCNT_W-1:0] limit;

   assign limit = (row_count_ff > prce_pkg::ROW_COUNT_W'(prce_pkg::PALETTE_ROWS))
                ? prce_pkg::ROWCNT_W'(prce_pkg::PALETTE_ROWS)
                : prce_pkg::ROWCNT_W'(row_count_ff);

   always_ff @(posedge clock) begin
      if (cmd.start_pixel) begin
         row_ctr_ff <= '0;
         hit_ff     <= 1'b0;
      end else if (cmd.srch_next) begin
         row_ctr_ff <= row_ctr_ff + 1'b1;
      end else if (cmd.srch_hit) begin
         hit_ff     <= 1'b1;
         hit_row_ff <= row_ctr_ff[prce_pkg::ROW_W-1:0];
         hit_len_ff <= len_rd;
      end
   end

   // result register
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [prce_pkg::COLOR_W-1:0]  rsp_color_ff;
   logic [prce_pkg::DEST_X_W-1:0] rsp_dx_ff;
   logic [prce_pkg::COORD_W-1:0]  rsp_dy_ff;
   logic [prce_pkg::NUM_W-1:0]    rsp_num_ff;
   logic                          rsp_matched_ff;
   logic                          rsp_short_ff;
   logic                          rsp_last_ff;
   logic                          in_chain;

   assign in_chain     = prce_pkg::LEN_W'(n_ff) < hit_len_ff;
   assign rsp_valid_in = cmd.emit_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp_color_ff   <= (hit_ff && in_chain) ? pal_rd_ff : pcolor_ff;
         rsp_dx_ff      <= dx_in;
         rsp_dy_ff      <= py_ff;
         rsp_num_ff     <= n_ff;
         rsp_matched_ff <= hit_ff;
         rsp_short_ff   <= hit_ff && !in_chain;
         rsp_last_ff    <= (n_ff == exp_count_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_num_ff, rsp_dy_ff, rsp_dx_ff, rsp_color_ff};
   assign rsp_tuser  = {rsp_short_ff, rsp_matched_ff};
   assign rsp_tlast  = rsp_last_ff;

   // status
   assign sts.cnt_zero   = (exp_count_ff == '0);
   assign sts.limit_zero = (limit == '0);
   assign sts.row_match  = (len_rd != '0) && (pal_rd_ff == pcolor_ff);
   assign sts.row_last   = (prce_pkg::ROWCNT_W'(row_ctr_ff + 1'b1) >= limit);
   assign sts.shade_last = (n_ff == exp_count_ff);
   assign sts.out_stall  = rsp_valid_ff && !rsp_tready;

   // never overwrite a result that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_load |-> !(rsp_valid_ff && !rsp_tready))
      else $error("result register overwritten while held");

   // a short chain only exists for a matched row
   a_short_needs_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_short_ff || rsp_matched_ff))
      else $error("chain_short without a match");

   // copy numbers start at one
   a_num_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_num_ff != '0))
      else $error("copy number zero emitted");

   // the search never runs past the row limit
   a_search_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.srch_rd |-> (row_ctr_ff < limit))
      else $error("row search beyond limit");

endmodule
`default_nettype wire

### rtl/core/palette_row_color_expander_core.sv
// Top level of the palette row color expander: controller plus datapath.
//
// Channel  Dir  Handshake              Payload
// req_     in   req_tvalid/req_tready  tdata: load or pixel; tuser: kind; tlast: end of row
// rsp_     out  rsp_tvalid/rsp_tready  tdata: color, destination; tuser: flags; tlast: last copy
// csr_     in   csr_we                 csr_index selects register, csr_wdata carries its value
//
// Sequence: a load is written in ST_IDLE. A pixel is taken in ST_IDLE; each row examined
// until the first match (at most min(row_count, 64)) runs ST_SRCH_RD and ST_SRCH_CHK, and
// each copy ST_EMIT_RD and ST_EMIT_CHK, as the palette memory has a single read port.
// Reset clears the counts, row lengths, controller state and result valid, sets the region
// width to one and keeps palette colors. The result register holds a copy until taken; the
// next copy waits behind it, and a new request is taken once the last copy is loaded.
`default_nettype none
module palette_row_color_expander_core (
   input  wire                                  clock,
   input  wire                                  reset,
   // configuration port
   input  wire                                  csr_we,
   input  wire  [prce_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [prce_pkg::CSR_DATA_W-1:0]      csr_wdata,
   // request stream
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // req_tdata, lowest bit up: row_index[5:0], shade_index[8:6], entry_color[40:9],
   // pixel_color[72:41], pixel_x[84:73], pixel_y[96:85], zero fill[103:97]
   input  wire  [prce_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  wire                                  req_tuser,  // req_type
   input  wire                                  req_tlast,  // end_of_row
   // result stream
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // rsp_tdata, lowest bit up: out_color[31:0], dest_x[46:32], dest_y[58:47],
   // shade_number[61:59], zero fill[63:62]
   output logic [prce_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [prce_pkg::RSP_USER_W-1:0]      rsp_tuser,  // matched[0], chain_short[1]
   output logic                                 rsp_tlast   // last
);

   prce_pkg::cmd_type    cmd;
   prce_pkg::status_type sts;

   // sequence the search and the copies
   prce_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // hold the palette, compare leaders, build results
   prce_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule
`default_nettype wire
